### hdl/daas_pkg.sv
// ============================================================================
// daas_pkg
// Shared widths, register codes, reset values and types of the dual ADC
// average, speed and angle block.
// ============================================================================
package daas_pkg;

    localparam int DAAS_WINDOW = 8;

    localparam int SAMPLE_W = 10;
    localparam int SPAN_W   = 8;
    localparam int FS_W     = 10;
    localparam int SCALED_W = 8;
    localparam int PROD_W   = SAMPLE_W + SPAN_W;
    localparam int MAG_W    = 7;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_SPAN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_FS   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_SPAN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_FS   = 2'd3;

    localparam logic [SPAN_W-1:0] SPEED_SPAN_RST = 8'd198;
    localparam logic [FS_W-1:0]   SPEED_FS_RST   = 10'd1023;
    localparam logic [SPAN_W-1:0] ANGLE_SPAN_RST = 8'd180;
    localparam logic [FS_W-1:0]   ANGLE_FS_RST   = 10'd1023;

    typedef enum logic [2:0] {
        LANE_IDLE,
        LANE_UPDATE,
        LANE_AVG,
        LANE_SCALE,
        LANE_DIV_SCALE,
        LANE_DONE
    } lane_state_t;

    typedef struct packed {
        logic start;
        logic take;
    } lane_ctrl_t;

    typedef struct packed {
        logic                done;
        logic [SCALED_W-1:0] result;
    } lane_stat_t;

endpackage

### hdl/daas_lane.sv
// ============================================================================
// daas_lane
// One channel: sample ring, running sum, a reciprocal multiply for the window
// average and a restoring divider for the full-scale ratio.
// ============================================================================
module daas_lane
    import daas_pkg::*;
#(
    parameter int WINDOW = DAAS_WINDOW
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  lane_ctrl_t                 ctrl,
    input  logic [SAMPLE_W-1:0]        sample,
    input  logic [$clog2(WINDOW)-1:0]  idx,
    input  logic [SPAN_W-1:0]          span,
    input  logic [FS_W-1:0]            full_scale,
    output lane_stat_t                 stat
);

    localparam int POS_W = $clog2(WINDOW);
    localparam int SUMW  = $clog2(((1 << SAMPLE_W) - 1) * WINDOW + 1);
    localparam int CNT_W = $clog2(PROD_W + 1);
    localparam logic [SUMW-1:0] SUM_MAX = SUMW'(((1 << SAMPLE_W) - 1) * WINDOW);

    // Rounded-up reciprocal of the window; the shifted product equals the
    // floor of sum / WINDOW for every sum that fits in SUMW bits.
    localparam int RECIP_K = SUMW + POS_W;
    localparam int RECIP_W = SUMW + 2;
    localparam int AVG_PW  = SUMW + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP_M =
        RECIP_W'(((1 << RECIP_K) + WINDOW - 1) / WINDOW);

    lane_state_t         state_reg, state_next;
    logic [WINDOW-1:0]   valid_reg;
    logic [SUMW-1:0]     sum_reg;
    logic [SUMW-1:0]     sum_next;
    logic [CNT_W-1:0]    cnt_reg;

    logic [SAMPLE_W-1:0] ring_mem [WINDOW];
    logic [SAMPLE_W-1:0] old_reg;
    logic [SAMPLE_W-1:0] sample_reg;
    logic [POS_W-1:0]    idx_reg;
    logic [SAMPLE_W-1:0] avg_reg;
    logic [PROD_W-1:0]   quo_reg;
    logic [FS_W-1:0]     rem_reg;

    logic [FS_W-1:0]     fs_eff;
    logic [FS_W:0]       trial;
    logic [FS_W:0]       trial_diff;
    logic                trial_ge;
    logic [AVG_PW-1:0]   avg_prod;
    logic [SAMPLE_W-1:0] avg_sat;
    logic [PROD_W-1:0]   prod;

    // A full-scale register of zero behaves as one.
    assign fs_eff     = (full_scale == '0) ? FS_W'(1) : full_scale;
    assign trial      = {rem_reg, quo_reg[PROD_W-1]};
    assign trial_ge   = (trial >= {1'b0, fs_eff});
    assign trial_diff = trial - {1'b0, fs_eff};

    assign sum_next = sum_reg - SUMW'(old_reg) + SUMW'(sample_reg);
    assign avg_prod = AVG_PW'(sum_reg) * AVG_PW'(RECIP_M);

    assign avg_sat = (avg_reg > fs_eff) ? fs_eff : avg_reg;
    assign prod    = PROD_W'(avg_sat) * PROD_W'(span);

    always_comb
    begin
        state_next  = state_reg;
        stat.done   = 1'b0;
        stat.result = quo_reg[SCALED_W-1:0];
        unique case (state_reg)
            LANE_IDLE:
            begin
                if (ctrl.start)
                begin
                    state_next = LANE_UPDATE;
                end
            end
            LANE_UPDATE:
            begin
                state_next = LANE_AVG;
            end
            LANE_AVG:
            begin
                state_next = LANE_SCALE;
            end
            LANE_SCALE:
            begin
                state_next = LANE_DIV_SCALE;
            end
            LANE_DIV_SCALE:
            begin
                if (cnt_reg == CNT_W'(1))
                begin
                    state_next = LANE_DONE;
                end
            end
            LANE_DONE:
            begin
                stat.done = 1'b1;
                if (ctrl.take)
                begin
                    state_next = LANE_IDLE;
                end
            end
            default:
            begin
                state_next = LANE_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= LANE_IDLE;
            valid_reg <= '0;
            sum_reg   <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            case (state_reg)
                LANE_UPDATE:
                begin
                    sum_reg            <= sum_next;
                    valid_reg[idx_reg] <= 1'b1;
                end
                LANE_SCALE:
                begin
                    cnt_reg <= CNT_W'(PROD_W);
                end
                LANE_DIV_SCALE:
                begin
                    cnt_reg <= cnt_reg - CNT_W'(1);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Ring storage and divider datapath. Entries never written read as zero
    // through the valid bits.
    always_ff @(posedge clk)
    begin
        case (state_reg)
            LANE_IDLE:
            begin
                if (ctrl.start)
                begin
                    sample_reg <= sample;
                    idx_reg    <= idx;
                    old_reg    <= valid_reg[idx] ? ring_mem[idx] : '0;
                end
            end
            LANE_UPDATE:
            begin
                ring_mem[idx_reg] <= sample_reg;
            end
            LANE_AVG:
            begin
                avg_reg <= avg_prod[RECIP_K +: SAMPLE_W];
            end
            LANE_SCALE:
            begin
                quo_reg <= prod;
                rem_reg <= '0;
            end
            LANE_DIV_SCALE:
            begin
                quo_reg <= {quo_reg[PROD_W-2:0], trial_ge};
                rem_reg <= trial_ge ? trial_diff[FS_W-1:0] : trial[FS_W-1:0];
            end
            default:
            begin
            end
        endcase
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.start |-> (state_reg == LANE_IDLE))
        else $error("lane started while busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        sum_reg <= SUM_MAX)
        else $error("running sum exceeds the ring capacity");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == LANE_DONE && !ctrl.take) |=>
            (state_reg == LANE_DONE && $stable(quo_reg)))
        else $error("lane result lost before it was taken");

endmodule

### hdl/daas_merge.sv
// ============================================================================
// daas_merge
// Combines the two lane results: centres the speed, saturates it to the
// signed byte range and derives its magnitude.
// ============================================================================
module daas_merge
    import daas_pkg::*;
(
    input  logic [SCALED_W-1:0]        speed_scaled,
    input  logic [SPAN_W-1:0]          speed_span,
    input  logic [SCALED_W-1:0]        angle_scaled,
    output logic signed [SCALED_W-1:0] speed_signed,
    output logic [MAG_W-1:0]           speed_magnitude,
    output logic [SCALED_W-1:0]        angle_value
);

    logic [SPAN_W-2:0]          half;
    logic signed [SCALED_W:0]   diff;
    logic signed [SCALED_W-1:0] sv;
    logic [SCALED_W-1:0]        sv_abs;

    assign half = speed_span[SPAN_W-1:1];
    assign diff = $signed({1'b0, speed_scaled}) - $signed({2'b00, half});

    // The lower bound of -127 is never passed, since the scaled value is
    // non-negative and half the span is at most 127.
    always_comb
    begin
        if (diff > $signed(9'sd127))
        begin
            sv = 8'sd127;
        end
        else
        begin
            sv = diff[SCALED_W-1:0];
        end
        sv_abs = sv[SCALED_W-1] ? (~sv + 8'd1) : sv;
    end

    assign speed_signed    = sv;
    assign speed_magnitude = sv_abs[MAG_W-1:0];
    assign angle_value     = angle_scaled;

endmodule

### hdl/dual_adc_average_speed_angle.sv
// ============================================================================
// dual_adc_average_speed_angle
// Boxcar average of two ADC channels, scaled to a signed speed with its
// magnitude and to an angle.
// ============================================================================
//
//  Channel  Direction  Payload                                      Handshake
//  s        in         tdata: speed_sample[9:0], angle_sample[19:10] tvalid/tready
//  m        out        tdata: speed_signed[7:0], speed_magnitude[14:8],
//                             angle_value[22:15]                    tvalid/tready
//  cfg      in         cfg_index, cfg_data                          cfg_wen
//
//  Each transaction passes, from acceptance to the output register, through the
//  ring update, the window average by reciprocal multiply, the scaling product,
//  the restoring divide by the full-scale register, and the hand-off. A new input
//  transaction is accepted the cycle after both lanes hand their result to the
//  output register, so no new sample pair is taken while one is in flight;
//  a result still waiting on m_tready holds the lanes done.
//  Reset clears the rings (through valid bits), sums and ring position at once.
// ============================================================================
module dual_adc_average_speed_angle
    import daas_pkg::*;
#(
    parameter int WINDOW = DAAS_WINDOW
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [23:0]           s_tdata,   // speed_sample, angle_sample, zero pad
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [23:0]           m_tdata,   // speed_signed, speed_magnitude,
                                             // angle_value, zero pad
    input  logic                  cfg_wen,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int POS_W = $clog2(WINDOW);

    logic [SPAN_W-1:0] speed_span_reg;
    logic [FS_W-1:0]   speed_fs_reg;
    logic [SPAN_W-1:0] angle_span_reg;
    logic [FS_W-1:0]   angle_fs_reg;

    logic [POS_W-1:0]  pos_reg;
    logic              busy_reg;
    logic              m_tvalid_reg;
    logic [23:0]       m_tdata_reg;

    logic              in_acc;
    logic              take;
    lane_ctrl_t        lane_ctrl;
    lane_stat_t        speed_stat;
    lane_stat_t        angle_stat;

    logic signed [SCALED_W-1:0] speed_signed;
    logic [MAG_W-1:0]           speed_magnitude;
    logic [SCALED_W-1:0]        angle_value;

    assign s_tready = !busy_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign take     = speed_stat.done && angle_stat.done && (!m_tvalid_reg || m_tready);

    assign lane_ctrl.start = in_acc;
    assign lane_ctrl.take  = take;

    daas_lane #(
        .WINDOW (WINDOW)
    ) u_speed_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .sample     (s_tdata[SAMPLE_W-1:0]),
        .idx        (pos_reg),
        .span       (speed_span_reg),
        .full_scale (speed_fs_reg),
        .stat       (speed_stat)
    );

    daas_lane #(
        .WINDOW (WINDOW)
    ) u_angle_lane (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (lane_ctrl),
        .sample     (s_tdata[2*SAMPLE_W-1:SAMPLE_W]),
        .idx        (pos_reg),
        .span       (angle_span_reg),
        .full_scale (angle_fs_reg),
        .stat       (angle_stat)
    );

    daas_merge u_merge (
        .speed_scaled    (speed_stat.result),
        .speed_span      (speed_span_reg),
        .angle_scaled    (angle_stat.result),
        .speed_signed    (speed_signed),
        .speed_magnitude (speed_magnitude),
        .angle_value     (angle_value)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_span_reg <= SPEED_SPAN_RST;
            speed_fs_reg   <= SPEED_FS_RST;
            angle_span_reg <= ANGLE_SPAN_RST;
            angle_fs_reg   <= ANGLE_FS_RST;
        end
        else if (cfg_wen)
        begin
            unique case (cfg_index)
                CFG_SPEED_SPAN: speed_span_reg <= cfg_data[SPAN_W-1:0];
                CFG_SPEED_FS:   speed_fs_reg   <= cfg_data[FS_W-1:0];
                CFG_ANGLE_SPAN: angle_span_reg <= cfg_data[SPAN_W-1:0];
                CFG_ANGLE_FS:   angle_fs_reg   <= cfg_data[FS_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            busy_reg     <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            if (in_acc)
            begin
                busy_reg <= 1'b1;
                if (pos_reg == POS_W'(WINDOW - 1))
                begin
                    pos_reg <= '0;
                end
                else
                begin
                    pos_reg <= pos_reg + POS_W'(1);
                end
            end
            else if (take)
            begin
                busy_reg <= 1'b0;
            end

            if (take)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            m_tdata_reg <= {1'b0, angle_value, speed_magnitude, speed_signed};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        speed_stat.done == angle_stat.done)
        else $error("speed and angle lanes out of step");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid_reg && !m_tready) |-> !take)
        else $error("pending output overwritten");

    assert property (@(posedge clk) disable iff (!rst_n)
        take |-> busy_reg)
        else $error("result delivered with no transaction in flight");

endmodule

### bench/dual_adc_average_speed_angle_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// dual_adc_average_speed_angle_tb
// Self-checking bench for the two-channel boxcar average with speed and angle
// scaling. A directed table covers reset, full-scale, clamping and degenerate
// register settings. Random register settings and random sample streams
// follow, all checked against a behavioral model of the filter kept here.
// ============================================================================
module dual_adc_average_speed_angle_tb;
    import daas_pkg::*;

    typedef struct packed {
        logic                pad;
        logic [SCALED_W-1:0] angle_value;
        logic [MAG_W-1:0]    speed_magnitude;
        logic [SCALED_W-1:0] speed_signed;
    } speed_angle_t;

    typedef enum logic [1:0] {
        ROW_WRITE,
        ROW_SAMPLE,
        ROW_CHECK
    } row_kind_t;

    typedef struct packed {
        row_kind_t             kind;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [SAMPLE_W-1:0]   value_a;    // register data, or speed sample
        logic [SAMPLE_W-1:0]   value_b;    // angle sample
        logic signed [7:0]     want_speed;
        logic [MAG_W-1:0]      want_magnitude;
        logic [SCALED_W-1:0]   want_angle;
    } stim_row_t;

    localparam int NUM_ROWS   = 35;
    localparam int NUM_PHASES = 8;
    localparam int PHASE_LEN  = 150;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [23:0]           s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [23:0]           m_tdata;
    logic                  cfg_wen;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Filter model state and register copies.
    int speed_hist [DAAS_WINDOW];
    int angle_hist [DAAS_WINDOW];
    int speed_total;
    int angle_total;
    int slot;
    int speed_span_r;
    int speed_fs_r;
    int angle_span_r;
    int angle_fs_r;

    speed_angle_t pending_results [$];

    bit src_idling;
    bit sink_idling;

    int mismatches;
    int samples_sent;
    int results_checked;
    int cfg_writes;
    int fs_saturations;
    int speed_clamps;

    stim_row_t directed_rows [NUM_ROWS] = '{
        '{ROW_CHECK,  '0, 10'd0,    10'd0,    -8'sd99, 7'd99,  8'd0},
        '{ROW_SAMPLE, '0, 10'd1023, 10'd1023, 8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd1023, 10'd1023, 8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd1023, 10'd1023, 8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd1023, 10'd1023, 8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd1023, 10'd1023, 8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd1023, 10'd1023, 8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd1023, 10'd1023, 8'sd0,   7'd0,   8'd0},
        // The zero sample in the first slot is overwritten here.
        '{ROW_CHECK,  '0, 10'd1023, 10'd1023, 8'sd99,  7'd99,  8'd180},
        '{ROW_WRITE,  CFG_SPEED_SPAN, 10'd255, 10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_WRITE,  CFG_ANGLE_SPAN, 10'd255, 10'd0, 8'sd0, 7'd0, 8'd0},
        // Span 255 gives 128 after centring, which clamps to 127.
        '{ROW_CHECK,  '0, 10'd1023, 10'd1023, 8'sd127, 7'd127, 8'd255},
        '{ROW_WRITE,  CFG_SPEED_SPAN, 10'd0, 10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_WRITE,  CFG_SPEED_FS,   10'd0, 10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_WRITE,  CFG_ANGLE_SPAN, 10'd1, 10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_WRITE,  CFG_ANGLE_FS,   10'd0, 10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_CHECK,  '0, 10'd1023, 10'd1023, 8'sd0,   7'd0,   8'd1},
        '{ROW_WRITE,  CFG_SPEED_SPAN, 10'd1,   10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_WRITE,  CFG_SPEED_FS,   10'd100, 10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_WRITE,  CFG_ANGLE_SPAN, 10'd200, 10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_WRITE,  CFG_ANGLE_FS,   10'd100, 10'd0, 8'sd0, 7'd0, 8'd0},
        // Averages far above full scale saturate, so the full span comes out.
        '{ROW_CHECK,  '0, 10'd1023, 10'd1023, 8'sd1,   7'd1,   8'd200},
        '{ROW_SAMPLE, '0, 10'd0,    10'd0,    8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd0,    10'd0,    8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd0,    10'd0,    8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd0,    10'd0,    8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd0,    10'd0,    8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd0,    10'd0,    8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd0,    10'd0,    8'sd0,   7'd0,   8'd0},
        '{ROW_CHECK,  '0, 10'd0,    10'd0,    8'sd0,   7'd0,   8'd0},
        '{ROW_WRITE,  CFG_SPEED_SPAN, 10'd2,    10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_WRITE,  CFG_SPEED_FS,   10'd1023, 10'd0, 8'sd0, 7'd0, 8'd0},
        '{ROW_SAMPLE, '0, 10'h2AA,  10'h155,  8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'h155,  10'h2AA,  8'sd0,   7'd0,   8'd0},
        '{ROW_SAMPLE, '0, 10'd1,    10'd512,  8'sd0,   7'd0,   8'd0}
    };

    dual_adc_average_speed_angle u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),    // speed_sample, angle_sample, zero pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),    // speed_signed, speed_magnitude, angle_value, pad
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("dual_adc_average_speed_angle_tb: FAIL");
        $finish;
    end

    // Saturate the average to full scale, then take avg * span / full scale.
    function automatic int ratio_scale(input int avg, input int span, input int fs);
        int limit;
        limit = (fs == 0) ? 1 : fs;
        if (avg > limit)
        begin
            avg = limit;
            fs_saturations++;
        end
        return (avg * span) / limit;
    endfunction

    function automatic speed_angle_t filter_step(input logic [SAMPLE_W-1:0] spd,
                                                 input logic [SAMPLE_W-1:0] ang);
        speed_angle_t r;
        int           centred;
        speed_total      = speed_total - speed_hist[slot] + int'(spd);
        speed_hist[slot] = int'(spd);
        angle_total      = angle_total - angle_hist[slot] + int'(ang);
        angle_hist[slot] = int'(ang);
        slot             = (slot + 1) % DAAS_WINDOW;

        centred = ratio_scale(speed_total / DAAS_WINDOW, speed_span_r, speed_fs_r)
                  - (speed_span_r >> 1);
        if (centred > 127)
        begin
            centred = 127;
            speed_clamps++;
        end
        if (centred < -127)
            centred = -127;

        r.pad             = 1'b0;
        r.speed_signed    = centred[7:0];
        r.speed_magnitude = MAG_W'((centred < 0) ? -centred : centred);
        r.angle_value     = SCALED_W'(ratio_scale(angle_total / DAAS_WINDOW,
                                                  angle_span_r, angle_fs_r));
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample(input int mode,
                                                        input int level);
        int v;
        case (mode)
            0: v = $urandom_range(0, 1023);
            1: v = level + $urandom_range(0, 32) - 16;
            2: v = $urandom_range(0, 1) ? 1023 : 0;
            default: v = level;
        endcase
        if (v < 0)
            v = 0;
        if (v > 1023)
            v = 1023;
        return v[SAMPLE_W-1:0];
    endfunction

    // Lower tvalid and hold off until every predicted result has been seen.
    task automatic drain_results();
        @(negedge clk);
        s_tvalid = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_wen   = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(negedge clk);
        cfg_wen = 1'b0;
        case (idx)
            CFG_SPEED_SPAN: speed_span_r = int'(value[SPAN_W-1:0]);
            CFG_SPEED_FS:   speed_fs_r   = int'(value[FS_W-1:0]);
            CFG_ANGLE_SPAN: angle_span_r = int'(value[SPAN_W-1:0]);
            CFG_ANGLE_FS:   angle_fs_r   = int'(value[FS_W-1:0]);
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Present one sample pair; at acceptance, advance the model and queue the
    // result it predicts, or the hand-written one when that is given.
    task automatic send_sample(input logic [SAMPLE_W-1:0] spd,
                               input logic [SAMPLE_W-1:0] ang,
                               input bit                  use_typed,
                               input speed_angle_t        typed);
        speed_angle_t predicted;
        @(negedge clk);
        if (src_idling && $urandom_range(0, 2) == 0)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {4'b0, ang, spd};
        do
            @(posedge clk);
        while (!s_tready);
        predicted = filter_step(spd, ang);
        pending_results.push_back(use_typed ? typed : predicted);
        samples_sent++;
    endtask

    task automatic randomize_registers();
        logic [CFG_DATA_W-1:0] value;
        value = CFG_DATA_W'($urandom_range(0, 1023));
        case ($urandom_range(0, 5))
            0: value[SPAN_W-1:0] = 8'd0;
            1: value[SPAN_W-1:0] = 8'd1;
            2: value[SPAN_W-1:0] = 8'd255;
            3: value[SPAN_W-1:0] = 8'd2;
            default: ;
        endcase
        write_register(CFG_SPEED_SPAN, value);
        value = CFG_DATA_W'($urandom_range(0, 1023));
        case ($urandom_range(0, 5))
            0: value[SPAN_W-1:0] = 8'd0;
            1: value[SPAN_W-1:0] = 8'd255;
            2: value[SPAN_W-1:0] = 8'd1;
            default: ;
        endcase
        write_register(CFG_ANGLE_SPAN, value);
        case ($urandom_range(0, 5))
            0: value = 10'd0;
            1: value = 10'd1;
            2: value = 10'd1023;
            default: value = CFG_DATA_W'($urandom_range(0, 1023));
        endcase
        write_register(CFG_SPEED_FS, value);
        case ($urandom_range(0, 5))
            0: value = 10'd0;
            1: value = 10'd1;
            2: value = 10'd1023;
            default: value = CFG_DATA_W'($urandom_range(0, 1023));
        endcase
        write_register(CFG_ANGLE_FS, value);
    endtask

    // Output side: random backpressure bursts.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_idling && $urandom_range(0, 3) == 0)
            begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge clk);
            end
            else
                m_tready = 1'b1;
        end
    end

    always @(posedge clk)
    begin
        speed_angle_t got;
        speed_angle_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata;
            if (pending_results.size() == 0)
            begin
                $error("result transaction 0x%06h arrived with none outstanding", m_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (got.speed_signed !== want.speed_signed)
                begin
                    $error("speed_signed: expected %0d, got %0d",
                           $signed(want.speed_signed), $signed(got.speed_signed));
                    mismatches++;
                end
                if (got.speed_magnitude !== want.speed_magnitude)
                begin
                    $error("speed_magnitude: expected %0d, got %0d",
                           want.speed_magnitude, got.speed_magnitude);
                    mismatches++;
                end
                if (got.angle_value !== want.angle_value)
                begin
                    $error("angle_value: expected %0d, got %0d",
                           want.angle_value, got.angle_value);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int                  mode;
        int                  burst_left;
        int                  level_s;
        int                  level_a;
        speed_angle_t        typed;
        logic [SAMPLE_W-1:0] spd;
        logic [SAMPLE_W-1:0] ang;

        s_tvalid  = 1'b0;
        s_tdata   = '0;
        cfg_wen   = 1'b0;
        cfg_index = CFG_SPEED_SPAN;
        cfg_data  = '0;
        rst_n     = 1'b0;

        for (int i = 0; i < DAAS_WINDOW; i++)
        begin
            speed_hist[i] = 0;
            angle_hist[i] = 0;
        end
        speed_total  = 0;
        angle_total  = 0;
        slot         = 0;
        speed_span_r = int'(SPEED_SPAN_RST);
        speed_fs_r   = int'(SPEED_FS_RST);
        angle_span_r = int'(ANGLE_SPAN_RST);
        angle_fs_r   = int'(ANGLE_FS_RST);
        src_idling   = 1'b1;
        sink_idling  = 1'b1;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
        begin
            case (directed_rows[i].kind)
                ROW_WRITE:
                begin
                    drain_results();
                    write_register(directed_rows[i].reg_index,
                                   directed_rows[i].value_a);
                end
                default:
                begin
                    typed = '{1'b0, directed_rows[i].want_angle,
                              directed_rows[i].want_magnitude,
                              directed_rows[i].want_speed};
                    send_sample(directed_rows[i].value_a, directed_rows[i].value_b,
                                directed_rows[i].kind == ROW_CHECK, typed);
                end
            endcase
        end

        typed = '0;
        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            drain_results();
            randomize_registers();
            // The closing phase runs flat out on both sides.
            src_idling  = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_idling = (phase != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            burst_left  = 0;
            mode        = 0;
            level_s     = 0;
            level_a     = 0;
            for (int n = 0; n < PHASE_LEN; n++)
            begin
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(8, 24);
                    mode       = $urandom_range(0, 3);
                    level_s    = $urandom_range(0, 1023);
                    level_a    = $urandom_range(0, 1023);
                end
                burst_left--;
                if (phase == 2 && n == PHASE_LEN / 2)
                    drain_results();
                spd = pick_sample(mode, level_s);
                ang = pick_sample(mode, level_a);
                send_sample(spd, ang, 1'b0, typed);
            end
        end

        drain_results();
        repeat (50) @(posedge clk);

        $display("Sent %0d sample pairs and checked %0d results over %0d register writes.",
                 samples_sent, results_checked, cfg_writes);
        $display("Full-scale saturation hit %0d times, positive speed clamp %0d times.",
                 fs_saturations, speed_clamps);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("dual_adc_average_speed_angle_tb: PASS");
        else
            $display("dual_adc_average_speed_angle_tb: FAIL");
        $finish;
    end

endmodule

### filelist.f
hdl/daas_pkg.sv
hdl/daas_lane.sv
hdl/daas_merge.sv
hdl/dual_adc_average_speed_angle.sv
bench/dual_adc_average_speed_angle_tb.sv
